@@ hw/rtl/tlfs_pkg.sv @@
// tlfs_pkg: shared types, constants and lookup functions for the typed-length
// frame splitter. Used by the parser, the emitter, the core and the checker.
// No dependencies.
`default_nettype none

package tlfs_pkg;

    localparam logic [7:0] NAK_BYTE      = 8'h15;
    localparam logic [7:0] TYPE_BASE     = 8'h50;
    localparam logic [7:0] TYPE_DEV_A    = 8'h50;
    localparam logic [7:0] TYPE_DEV_B    = 8'h51;
    localparam logic [7:0] TYPE_SWITCHED = 8'h62;
    localparam int         TYPE_COUNT    = 36;
    localparam int         LEN_W         = 5;
    localparam int         SWITCH_COUNT  = 6;   // byte 5 just stored
    localparam int         SWITCH_BIT    = 4;
    localparam logic [LEN_W-1:0] SHORT_LEN = 5'd9;

    // holds a byte count for any frame length the table can give (up to 31)
    localparam int CNT_W = 6;

    localparam logic [1:0] KIND_NAK    = 2'd0;
    localparam logic [1:0] KIND_DEVICE = 2'd1;
    localparam logic [1:0] KIND_OTHER  = 2'd2;

    localparam logic [1:0] STATUS_FRAME   = 2'd0;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
    localparam logic [1:0] STATUS_TRUNC   = 2'd2;

    localparam logic [LEN_W-1:0] LEN_TABLE [TYPE_COUNT] = '{
        5'd11, 5'd25, 5'd4,  5'd10, 5'd3,  5'd2,  5'd13, 5'd10, 5'd3,
        5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
        5'd9,  5'd6,  5'd23, 5'd5,  5'd5,  5'd3,  5'd6,  5'd3,  5'd4,
        5'd3,  5'd3,  5'd4,  5'd3,  5'd3,  5'd3,  5'd12,
        5'd4,  5'd5,  5'd3,  5'd6
    };

    typedef enum logic [1:0] {
        E_IDLE,
        E_READ,
        E_OUT
    } tlfs_emit_state_t;

    // one result run handed from the parser to the emitter
    typedef struct packed {
        logic             valid;
        logic             direct;   // single result, no store read
        logic [7:0]       data;
        logic [7:0]       ftype;
        logic [1:0]       kind;
        logic [1:0]       status;
        logic [CNT_W-1:0] count;
    } tlfs_job_t;

    // 0 means unknown type
    function automatic logic [LEN_W-1:0] type_length(input logic [7:0] t);
        logic [7:0]       off;
        logic [LEN_W-1:0] len;
        off = t - TYPE_BASE;
        len = '0;
        if (t >= TYPE_BASE && off < 8'(TYPE_COUNT))
        begin
            len = LEN_TABLE[off[5:0]];
        end
        return len;
    endfunction

    function automatic logic [1:0] kind_of(input logic [7:0] t);
        return (t == TYPE_DEV_A || t == TYPE_DEV_B) ? KIND_DEVICE : KIND_OTHER;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tlfs_frame_mem.sv @@
// tlfs_frame_mem: frame byte store, one write port and one read port with
// registered read data. No dependencies.
`default_nettype none

module tlfs_frame_mem #(
    parameter int DEPTH = 25,
    parameter int AW    = 5
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/tlfs_parser.sv @@
// tlfs_parser: per-byte framing state, writes frame bytes to the store and
// issues result runs to the emitter. Depends on tlfs_pkg.
`default_nettype none

module tlfs_parser
    import tlfs_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 25,
    parameter int AW              = 5,
    parameter int PW              = 5
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    in_byte,
    input  wire logic          chunk_end,
    output tlfs_job_t          job,
    output logic               wr_en,
    output logic      [AW-1:0] wr_addr,
    output logic      [7:0]    wr_data
);

    localparam int CW = PW + 1;

    logic [PW-1:0]    pos_reg, pos_next;
    logic [LEN_W-1:0] exp_reg, exp_next;
    logic             discard_reg, discard_next;
    logic             prev_nak_reg, prev_nak_next;
    logic [7:0]       type_reg, type_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            exp_reg      <= '0;
            discard_reg  <= 1'b0;
            prev_nak_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            exp_reg      <= exp_next;
            discard_reg  <= discard_next;
            prev_nak_reg <= prev_nak_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg <= type_next;
    end

    always_comb
    begin
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] eff_len;
        logic [CW-1:0]    cnt;
        logic [7:0]       cur_type;
        logic             check;

        pos_next      = pos_reg;
        exp_next      = exp_reg;
        discard_next  = discard_reg;
        prev_nak_next = prev_nak_reg;
        type_next     = type_reg;
        job           = '0;
        wr_en         = 1'b0;
        wr_addr       = pos_reg[AW-1:0];
        wr_data       = in_byte;
        len           = type_length(in_byte);
        eff_len       = exp_reg;
        cnt           = CW'(pos_reg) + CW'(1);
        cur_type      = type_reg;
        check         = 1'b0;

        if (accept)
        begin
            if (discard_reg)
            begin
                if (chunk_end)
                begin
                    discard_next  = 1'b0;
                    pos_next      = '0;
                    prev_nak_next = 1'b0;
                end
            end
            else if (pos_reg == '0)
            begin
                if (in_byte == NAK_BYTE)
                begin
                    if (prev_nak_reg)
                    begin
                        prev_nak_next = 1'b0;   // doubled nak is swallowed
                    end
                    else
                    begin
                        job.valid     = 1'b1;
                        job.direct    = 1'b1;
                        job.data      = NAK_BYTE;
                        job.ftype     = NAK_BYTE;
                        job.kind      = KIND_NAK;
                        job.status    = STATUS_FRAME;
                        prev_nak_next = 1'b1;
                    end
                    if (chunk_end)
                    begin
                        prev_nak_next = 1'b0;
                    end
                end
                else
                begin
                    prev_nak_next = 1'b0;
                    wr_en         = 1'b1;
                    pos_next      = PW'(1);
                    if (chunk_end)
                    begin
                        job.valid  = 1'b1;
                        job.direct = 1'b1;
                        job.kind   = KIND_OTHER;
                        job.status = STATUS_TRUNC;
                        pos_next   = '0;
                    end
                end
            end
            else if (pos_reg == PW'(1))
            begin
                if (len == '0)
                begin
                    job.valid    = 1'b1;
                    job.direct   = 1'b1;
                    job.ftype    = in_byte;
                    job.kind     = KIND_OTHER;
                    job.status   = STATUS_UNKNOWN;
                    pos_next     = '0;
                    discard_next = !chunk_end;
                end
                else
                begin
                    wr_en     = 1'b1;
                    type_next = in_byte;
                    cur_type  = in_byte;
                    eff_len   = len;
                    exp_next  = len;
                    check     = 1'b1;
                end
            end
            else
            begin
                wr_en = (CW'(pos_reg) < CW'(MAX_FRAME_BYTES));
                // type 0x62 shortens when the switch bit of byte 5 is clear
                if (type_reg == TYPE_SWITCHED && cnt == CW'(SWITCH_COUNT)
                    && !in_byte[SWITCH_BIT])
                begin
                    eff_len = SHORT_LEN;
                end
                exp_next = eff_len;
                check    = 1'b1;
            end

            if (check)
            begin
                pos_next = cnt[PW-1:0];
                if (cnt >= CW'(eff_len) || cnt >= CW'(MAX_FRAME_BYTES))
                begin
                    job.valid  = 1'b1;
                    job.ftype  = cur_type;
                    job.kind   = kind_of(cur_type);
                    job.status = STATUS_FRAME;
                    job.count  = CNT_W'(cnt);
                    pos_next   = '0;
                end
                else if (chunk_end)
                begin
                    job.valid  = 1'b1;
                    job.direct = 1'b1;
                    job.ftype  = cur_type;
                    job.kind   = kind_of(cur_type);
                    job.status = STATUS_TRUNC;
                    pos_next   = '0;
                end
                if (chunk_end)
                begin
                    prev_nak_next = 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/tlfs_emitter.sv @@
// tlfs_emitter: plays out one result run, reading frame bytes from the store
// one at a time. Depends on tlfs_pkg.
`default_nettype none

module tlfs_emitter
    import tlfs_pkg::*;
#(
    parameter int AW = 5
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire tlfs_job_t     job,
    output logic               busy,
    output logic               rd_en,
    output logic      [AW-1:0] rd_addr,
    input  wire logic [7:0]    rd_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic      [7:0]    out_byte,
    output logic      [7:0]    frame_type,
    output logic      [1:0]    frame_kind,
    output logic      [1:0]    status,
    output logic               frame_last
);

    tlfs_emit_state_t state_reg, state_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic             direct_reg;
    logic [7:0]       data_reg;
    logic [7:0]       type_reg;
    logic [1:0]       kind_reg;
    logic [1:0]       status_reg;
    logic [CNT_W-1:0] count_reg;
    logic             last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == E_IDLE && job.valid)
        begin
            direct_reg <= job.direct;
            data_reg   <= job.data;
            type_reg   <= job.ftype;
            kind_reg   <= job.kind;
            status_reg <= job.status;
            count_reg  <= job.count;
        end
    end

    assign last = direct_reg || (CNT_W'(idx_reg) + CNT_W'(1) == count_reg);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            E_IDLE:
            begin
                if (job.valid)
                begin
                    idx_next   = '0;
                    state_next = job.direct ? E_OUT : E_READ;
                end
            end
            E_READ:
            begin
                state_next = E_OUT;
            end
            E_OUT:
            begin
                if (out_ready)
                begin
                    if (last)
                    begin
                        state_next = E_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = E_READ;
                    end
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy      = (state_reg != E_IDLE);
        rd_en     = (state_reg == E_READ);
        out_valid = (state_reg == E_OUT);
    end

    assign rd_addr    = idx_reg;
    assign out_byte   = direct_reg ? data_reg : rd_data;
    assign frame_type = type_reg;
    assign frame_kind = kind_reg;
    assign status     = status_reg;
    assign frame_last = last;

endmodule

`default_nettype wire

@@ hw/rtl/typed_length_frame_splitter_core.sv @@
// Typed-length frame splitter: a byte with a chunk-end mark goes in each
// request; a byte that causes no result leaves the input ready, so the next
// may follow at once. Each frame byte is played out by a store read (E_READ)
// and then an output state (E_OUT) that waits for out_ready; a NAK or an
// error result goes straight to the output state with no store read. The
// input is held off while a run plays out. Frame bytes live in a
// single-port-write, registered-read store of MAX_FRAME_BYTES entries.
// Depends on tlfs_pkg, tlfs_parser, tlfs_emitter and tlfs_frame_mem.
`default_nettype none

module typed_length_frame_splitter_core
    import tlfs_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 25
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       chunk_end,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic      [7:0] out_byte,
    output logic      [7:0] frame_type,
    output logic      [1:0] frame_kind,
    output logic      [1:0] status,
    output logic            frame_last
);

    localparam int AW = $clog2(MAX_FRAME_BYTES);
    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);

    tlfs_job_t     job;
    logic          busy;
    logic          accept;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    assign in_ready = !busy;
    assign accept   = in_valid && in_ready;

    tlfs_parser #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
        .AW(AW),
        .PW(PW)
    ) u_parser (
        .clk(clk),
        .rst_n(rst_n),
        .accept(accept),
        .in_byte(in_byte),
        .chunk_end(chunk_end),
        .job(job),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data)
    );

    tlfs_frame_mem #(
        .DEPTH(MAX_FRAME_BYTES),
        .AW(AW)
    ) u_mem (
        .clk(clk),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en(rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    tlfs_emitter #(
        .AW(AW)
    ) u_emit (
        .clk(clk),
        .rst_n(rst_n),
        .job(job),
        .busy(busy),
        .rd_en(rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_byte(out_byte),
        .frame_type(frame_type),
        .frame_kind(frame_kind),
        .status(status),
        .frame_last(frame_last)
    );

endmodule

`default_nettype wire

@@ hw/rtl/tlfs_checker.sv @@
// tlfs_checker: port-level assertions for the frame splitter, bound to the
// top level. Depends on tlfs_pkg and typed_length_frame_splitter_core.
`default_nettype none

module tlfs_checker
    import tlfs_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic [7:0] frame_type,
    input wire logic [1:0] frame_kind,
    input wire logic [1:0] status,
    input wire logic       frame_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(frame_type) && $stable(status) && $stable(frame_last))
        else $error("stalled result changed");

    // no request taken while a run is playing out
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted during result run");

    // error results are single and carry no byte
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_FRAME |-> frame_last && out_byte == 8'h00)
        else $error("error result malformed");

    a_nak_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_kind == KIND_NAK |->
            frame_type == NAK_BYTE && out_byte == NAK_BYTE && frame_last)
        else $error("nak result malformed");

    a_dev_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_kind == KIND_DEVICE |->
            frame_type == TYPE_DEV_A || frame_type == TYPE_DEV_B)
        else $error("device kind with wrong type");

endmodule

bind typed_length_frame_splitter_core tlfs_checker u_tlfs_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .frame_type(frame_type),
    .frame_kind(frame_kind),
    .status(status),
    .frame_last(frame_last)
);

`default_nettype wire
